@@ sv/bpm_pkg.sv @@
// Shared types, constants and codes for the buffer pool manager.
package bpm_pkg;

    localparam int DEPTH      = 16;
    localparam int POS_BITS   = $clog2(DEPTH);
    localparam int CNT_BITS   = $clog2(DEPTH + 1);
    localparam int ADDR_BITS  = 32;
    localparam int SIZE_BITS  = 24;
    localparam int ACT_BITS   = 3;
    localparam int STAT_BITS  = 3;
    localparam int INDEX_BITS = 4;

    localparam logic [ACT_BITS-1:0] ACT_ADD      = 3'd0;
    localparam logic [ACT_BITS-1:0] ACT_REM_ADDR = 3'd1;
    localparam logic [ACT_BITS-1:0] ACT_REM_FREE = 3'd2;
    localparam logic [ACT_BITS-1:0] ACT_TAKE     = 3'd3;
    localparam logic [ACT_BITS-1:0] ACT_GIVE     = 3'd4;
    localparam logic [ACT_BITS-1:0] ACT_FREE_ALL = 3'd5;
    localparam logic [ACT_BITS-1:0] ACT_READ     = 3'd6;

    localparam logic [STAT_BITS-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_BITS-1:0] ST_NONE_FREE = 3'd1;
    localparam logic [STAT_BITS-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STAT_BITS-1:0] ST_FULL      = 3'd3;
    localparam logic [STAT_BITS-1:0] ST_BAD_INDEX = 3'd4;

    typedef struct packed {
        logic [ACT_BITS-1:0]   action;
        logic [ADDR_BITS-1:0]  buf_addr;
        logic [SIZE_BITS-1:0]  buf_size;
        logic [INDEX_BITS-1:0] index;
    } t_in_item;

    typedef struct packed {
        logic [STAT_BITS-1:0] status;
        logic [ADDR_BITS-1:0] out_addr;
        logic [SIZE_BITS-1:0] out_size;
        logic                 entry_free;
        logic [CNT_BITS-1:0]  entry_count;
    } t_out_item;

    typedef struct packed {
        logic                 exec;
        logic [ACT_BITS-1:0]  action;
        logic [ADDR_BITS-1:0] addr;
        logic [SIZE_BITS-1:0] size;
        logic [CNT_BITS-1:0]  count;
    } t_cmd;

    typedef struct packed {
        logic addr_seen;
        logic free_seen;
    } t_chain;

    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        logic [SIZE_BITS-1:0] len;
        logic                 free;
    } t_entry;

endpackage

@@ sv/bpm_cell.sv @@
// One table position: holds an entry, matches it and shifts from its upper neighbor.
module bpm_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bpm_pkg::t_cmd                 i_cmd,
    input  logic [bpm_pkg::POS_BITS-1:0]  i_pos,
    input  bpm_pkg::t_chain               i_chain,
    input  bpm_pkg::t_entry               i_next,
    output bpm_pkg::t_chain               o_chain,
    output bpm_pkg::t_entry               o_entry,
    output logic                          o_first_free
);
    import bpm_pkg::*;

    logic [ADDR_BITS-1:0] r_addr, n_addr;
    logic [SIZE_BITS-1:0] r_len, n_len;
    logic                 r_free, n_free;
    logic                 w_used, w_tail, w_addr_hit, w_free_hit, w_first_addr;

    assign w_used       = CNT_BITS'(i_pos) < i_cmd.count;
    assign w_tail       = CNT_BITS'(i_pos) == i_cmd.count;
    assign w_addr_hit   = w_used & (r_addr == i_cmd.addr);
    assign w_free_hit   = w_used & r_free;
    assign w_first_addr = w_addr_hit & ~i_chain.addr_seen;
    assign o_first_free = w_free_hit & ~i_chain.free_seen;

    assign o_chain.addr_seen = i_chain.addr_seen | w_addr_hit;
    assign o_chain.free_seen = i_chain.free_seen | w_free_hit;

    assign o_entry.addr = r_addr;
    assign o_entry.len  = r_len;
    assign o_entry.free = r_free;

    always_comb begin
        n_addr = r_addr;
        n_len  = r_len;
        n_free = r_free;
        if (i_cmd.exec) begin
            unique case (i_cmd.action)
                ACT_ADD: begin
                    if (w_tail) begin
                        n_addr = i_cmd.addr;
                        n_len  = i_cmd.size;
                        n_free = 1'b1;
                    end
                end
                ACT_REM_ADDR: begin
                    if (o_chain.addr_seen) begin
                        n_addr = i_next.addr;
                        n_len  = i_next.len;
                        n_free = i_next.free;
                    end
                end
                ACT_REM_FREE: begin
                    if (o_chain.free_seen) begin
                        n_addr = i_next.addr;
                        n_len  = i_next.len;
                        n_free = i_next.free;
                    end
                end
                ACT_TAKE: begin
                    if (o_first_free) begin
                        n_free = 1'b0;
                    end
                end
                ACT_GIVE: begin
                    if (w_first_addr) begin
                        n_free = 1'b1;
                    end
                end
                ACT_FREE_ALL: begin
                    if (w_used) begin
                        n_free = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= 1'b0;
        end else begin
            r_free <= n_free;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_len  <= n_len;
    end

endmodule

@@ sv/buffer_pool_manager_core.sv @@
// Top level of the buffer pool manager: command register, cell row and result register.
//
// The block keeps a packed table of up to 16 buffers, each with address, size
// and free flag, in a row of cells; each cell holds one entry and can load its
// upper neighbor's entry when a remove closes the gap.
// The input channel (i_in_valid, o_in_stall, i_in_item) takes one item: add,
// remove by address, remove first free, take, give back, free all or read.
// The output channel (o_out_valid, i_out_stall, o_out_item) returns exactly
// one result item per input item, with the status and the entry count.
// An item is registered in the command register when it is accepted and is
// executed across all cells at once when the output register can take its
// result, which is then registered there. The single command register holds
// one item until it executes, so no new item is taken before the last executes.
// While the receiver stalls, the result waits in the output register; the
// next item is still accepted, but it does not execute until that register
// is free. Reset empties the table and clears both channels.
module buffer_pool_manager_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  bpm_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output bpm_pkg::t_out_item  o_out_item
);
    import bpm_pkg::*;

    logic                r_busy;
    logic                r_out_valid;
    logic [CNT_BITS-1:0] r_count, n_count;
    t_in_item            r_cmd;
    t_out_item           r_out_item, n_out_item;
    logic                w_fire;
    t_cmd                w_cmd;
    t_chain              w_chain [DEPTH+1];
    t_entry              w_entry [DEPTH];
    t_entry              w_next  [DEPTH];
    logic [DEPTH-1:0]    w_first_free;
    t_entry              w_take;
    t_entry              w_read;
    logic                w_full;

    assign o_in_stall  = r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign w_fire      = r_busy & (~r_out_valid | ~i_out_stall);
    assign w_full      = r_count == CNT_BITS'(DEPTH);

    assign w_cmd.exec   = w_fire;
    assign w_cmd.action = r_cmd.action;
    assign w_cmd.addr   = r_cmd.buf_addr;
    assign w_cmd.size   = r_cmd.buf_size;
    assign w_cmd.count  = r_count;

    assign w_chain[0] = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == DEPTH - 1) begin : g_last
            assign w_next[g] = '0;
        end else begin : g_mid
            assign w_next[g] = w_entry[g+1];
        end
        bpm_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_pos        (POS_BITS'(g)),
            .i_chain      (w_chain[g]),
            .i_next       (w_next[g]),
            .o_chain      (w_chain[g+1]),
            .o_entry      (w_entry[g]),
            .o_first_free (w_first_free[g])
        );
    end

    always_comb begin
        w_take = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (w_first_free[k]) begin
                w_take = w_take | w_entry[k];
            end
        end
    end

    assign w_read = w_entry[r_cmd.index[POS_BITS-1:0]];

    always_comb begin
        n_out_item        = '0;
        n_out_item.status = ST_OK;
        n_count           = r_count;
        unique case (r_cmd.action)
            ACT_ADD: begin
                if (w_full) begin
                    n_out_item.status = ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            ACT_REM_ADDR: begin
                if (w_chain[DEPTH].addr_seen) begin
                    n_count = r_count - 1'b1;
                end else begin
                    n_out_item.status = ST_NOT_FOUND;
                end
            end
            ACT_REM_FREE: begin
                if (w_chain[DEPTH].free_seen) begin
                    n_count = r_count - 1'b1;
                end else begin
                    n_out_item.status = ST_NONE_FREE;
                end
            end
            ACT_TAKE: begin
                if (w_chain[DEPTH].free_seen) begin
                    n_out_item.out_addr = w_take.addr;
                    n_out_item.out_size = w_take.len;
                end else begin
                    n_out_item.status = ST_NONE_FREE;
                end
            end
            ACT_GIVE: begin
                if (!w_chain[DEPTH].addr_seen) begin
                    n_out_item.status = ST_NOT_FOUND;
                end
            end
            ACT_READ: begin
                if (CNT_BITS'(r_cmd.index) >= r_count) begin
                    n_out_item.status = ST_BAD_INDEX;
                end else begin
                    n_out_item.out_addr   = w_read.addr;
                    n_out_item.entry_free = w_read.free;
                end
            end
            default: begin
            end
        endcase
        n_out_item.entry_count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (i_in_valid && !r_busy) begin
                r_busy <= 1'b1;
            end else if (w_fire) begin
                r_busy <= 1'b0;
            end
            r_out_valid <= w_fire | (r_out_valid & i_out_stall);
            if (w_fire) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !r_busy) begin
            r_cmd <= i_in_item;
        end
        if (w_fire) begin
            r_out_item <= n_out_item;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(DEPTH))
        else $error("entry count exceeds table depth");

    a_one_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_first_free))
        else $error("more than one cell selected as first free");

    a_fire_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> o_out_valid)
        else $error("executed item produced no result");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fire |=> $stable(r_count))
        else $error("entry count changed without an executed item");
`endif

endmodule

@@ tb/buffer_pool_manager_core_tb.sv @@
// Self-checking testbench for the buffer pool manager: directed table, then random items.
`timescale 1ns / 100ps

module buffer_pool_manager_core_tb;
    import bpm_pkg::*;

    localparam logic [ACT_BITS-1:0] ACT_UNUSED = 3'd7;
    localparam int IDLE_PCT     = 32;
    localparam int RANDOM_ITEMS = 900;
    localparam int STUCK_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        t_in_item  item;
        logic      has_exp;
        t_out_item exp;
    } t_row;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    logic [ADDR_BITS-1:0] slot_addr_q [DEPTH];
    logic [SIZE_BITS-1:0] slot_len_q [DEPTH];
    logic                 slot_free_q [DEPTH];
    int                   slot_total = 0;

    t_out_item            pending_results [$];
    t_row                 directed_rows [$];
    logic [ADDR_BITS-1:0] addr_pool [8];
    logic                 row_has_exp = 1'b0;
    t_out_item            row_exp = '0;
    bit                   calm = 1'b0;
    int                   error_count = 0;
    int                   stuck_cycles = 0;
    int                   items_in = 0;
    int                   results_out = 0;
    int                   peak_count = 0;
    int                   status_seen [8];

    int unsigned mix [3][8] = '{'{55, 5, 5, 15, 8, 2, 8, 2},
                                '{25, 12, 10, 20, 15, 3, 13, 2},
                                '{10, 25, 20, 15, 10, 5, 13, 2}};

    buffer_pool_manager_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // Applies one item to the table copy and returns the result it should produce.
    function automatic t_out_item pool_apply(input t_in_item it);
        t_out_item res;
        int k;
        int addr_hit;
        int free_hit;
        int hit;
        res = '0;
        addr_hit = -1;
        free_hit = -1;
        for (k = slot_total - 1; k >= 0; k--) begin
            if (slot_addr_q[k] == it.buf_addr) addr_hit = k;
            if (slot_free_q[k]) free_hit = k;
        end
        case (it.action)
            ACT_ADD: begin
                if (slot_total >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    slot_addr_q[slot_total] = it.buf_addr;
                    slot_len_q[slot_total] = it.buf_size;
                    slot_free_q[slot_total] = 1'b1;
                    slot_total++;
                end
            end
            ACT_REM_ADDR, ACT_REM_FREE: begin
                hit = (it.action == ACT_REM_ADDR) ? addr_hit : free_hit;
                if (hit < 0) begin
                    res.status = (it.action == ACT_REM_ADDR) ? ST_NOT_FOUND : ST_NONE_FREE;
                end else begin
                    for (k = hit; k < slot_total - 1; k++) begin
                        slot_addr_q[k] = slot_addr_q[k + 1];
                        slot_len_q[k] = slot_len_q[k + 1];
                        slot_free_q[k] = slot_free_q[k + 1];
                    end
                    slot_total--;
                end
            end
            ACT_TAKE: begin
                if (free_hit < 0) begin
                    res.status = ST_NONE_FREE;
                end else begin
                    slot_free_q[free_hit] = 1'b0;
                    res.out_addr = slot_addr_q[free_hit];
                    res.out_size = slot_len_q[free_hit];
                end
            end
            ACT_GIVE: begin
                if (addr_hit < 0) res.status = ST_NOT_FOUND;
                else slot_free_q[addr_hit] = 1'b1;
            end
            ACT_FREE_ALL: begin
                for (k = 0; k < slot_total; k++) slot_free_q[k] = 1'b1;
            end
            ACT_READ: begin
                if (it.index >= slot_total) begin
                    res.status = ST_BAD_INDEX;
                end else begin
                    res.out_addr = slot_addr_q[it.index];
                    res.entry_free = slot_free_q[it.index];
                end
            end
            default: begin
            end
        endcase
        res.entry_count = CNT_BITS'(slot_total);
        return res;
    endfunction

    function automatic t_row plan_row(
        input logic [ACT_BITS-1:0]   act,
        input logic [ADDR_BITS-1:0]  addr,
        input logic [SIZE_BITS-1:0]  size,
        input logic [INDEX_BITS-1:0] idx,
        input logic                  chk,
        input logic [STAT_BITS-1:0]  st,
        input logic [ADDR_BITS-1:0]  oaddr,
        input logic [SIZE_BITS-1:0]  osize,
        input logic                  ofree,
        input logic [CNT_BITS-1:0]   cnt
    );
        t_row r;
        r.item.action = act;
        r.item.buf_addr = addr;
        r.item.buf_size = size;
        r.item.index = idx;
        r.has_exp = chk;
        r.exp.status = st;
        r.exp.out_addr = oaddr;
        r.exp.out_size = osize;
        r.exp.entry_free = ofree;
        r.exp.entry_count = cnt;
        return r;
    endfunction

    task automatic queue_row(input t_row r);
        directed_rows = {directed_rows, r};
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    // Presents one item from the falling edge on and holds it until it is taken.
    task automatic send_item(input t_row r);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= r.item;
        row_has_exp = r.has_exp;
        row_exp = r.exp;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    always @(negedge clk) begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge clk) begin
        t_out_item want;
        logic moved;
        moved = 1'b0;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                want = pool_apply(in_item);
                if (row_has_exp) want = row_exp;
                pending_results = {pending_results, want};
                items_in++;
                moved = 1'b1;
            end
            if (out_valid && !out_stall) begin
                moved = 1'b1;
                results_out++;
                if (pending_results.size() == 0) begin
                    $error("Result item arrived with no item outstanding");
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    status_seen[want.status]++;
                    if (want.entry_count > peak_count) peak_count = int'(want.entry_count);
                    check_field("status", 32'(want.status), 32'(out_item.status));
                    check_field("out_addr", want.out_addr, out_item.out_addr);
                    check_field("out_size", 32'(want.out_size), 32'(out_item.out_size));
                    check_field("entry_free", 32'(want.entry_free),
                                32'(out_item.entry_free));
                    check_field("entry_count", 32'(want.entry_count),
                                32'(out_item.entry_count));
                end
            end
            stuck_cycles = moved ? 0 : stuck_cycles + 1;
        end
    end

    initial begin
        t_row r;
        int n;
        int k;
        int a;
        int acc;
        int pick;
        int mode;
        int roll;
        foreach (status_seen[s]) status_seen[s] = 0;
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        for (k = 2; k < 8; k++) addr_pool[k] = $urandom;

        // Empty table: every lookup fails, free all and the unused code do nothing.
        queue_row(plan_row(ACT_READ, '0, '0, 4'd0, 1'b1, ST_BAD_INDEX,
                           '0, '0, 1'b0, 5'd0));
        queue_row(plan_row(ACT_TAKE, '0, '0, 4'd0, 1'b1, ST_NONE_FREE,
                           '0, '0, 1'b0, 5'd0));
        queue_row(plan_row(ACT_REM_FREE, '0, '0, 4'd0, 1'b1, ST_NONE_FREE,
                           '0, '0, 1'b0, 5'd0));
        queue_row(plan_row(ACT_REM_ADDR, '1, '1, 4'd15, 1'b1, ST_NOT_FOUND,
                           '0, '0, 1'b0, 5'd0));
        queue_row(plan_row(ACT_GIVE, '0, '0, 4'd0, 1'b1, ST_NOT_FOUND,
                           '0, '0, 1'b0, 5'd0));
        queue_row(plan_row(ACT_FREE_ALL, '1, '1, 4'd15, 1'b1, ST_OK,
                           '0, '0, 1'b0, 5'd0));
        queue_row(plan_row(ACT_UNUSED, '1, '1, 4'd15, 1'b1, ST_OK,
                           '0, '0, 1'b0, 5'd0));
        // Extreme fields and a duplicate address.
        queue_row(plan_row(ACT_ADD, '1, '1, 4'd0, 1'b1, ST_OK, '0, '0, 1'b0, 5'd1));
        queue_row(plan_row(ACT_ADD, '0, '0, 4'd15, 1'b1, ST_OK, '0, '0, 1'b0, 5'd2));
        queue_row(plan_row(ACT_ADD, '1, 24'h123456, 4'd0, 1'b1, ST_OK,
                           '0, '0, 1'b0, 5'd3));
        queue_row(plan_row(ACT_READ, '0, '0, 4'd2, 1'b1, ST_OK, '1, '0, 1'b1, 5'd3));
        queue_row(plan_row(ACT_TAKE, '0, '0, 4'd0, 1'b1, ST_OK, '1, '1, 1'b0, 5'd3));
        queue_row(plan_row(ACT_GIVE, '1, '0, 4'd0, 1'b1, ST_OK, '0, '0, 1'b0, 5'd3));
        queue_row(plan_row(ACT_GIVE, '1, '0, 4'd0, 1'b1, ST_OK, '0, '0, 1'b0, 5'd3));
        queue_row(plan_row(ACT_TAKE, '0, '0, 4'd0, 1'b0, ST_OK, '0, '0, 1'b0, 5'd0));
        queue_row(plan_row(ACT_TAKE, '1, '1, 4'd15, 1'b0, ST_OK, '0, '0, 1'b0, 5'd0));
        queue_row(plan_row(ACT_TAKE, '0, '0, 4'd0, 1'b0, ST_OK, '0, '0, 1'b0, 5'd0));
        queue_row(plan_row(ACT_TAKE, '0, '0, 4'd0, 1'b1, ST_NONE_FREE,
                           '0, '0, 1'b0, 5'd3));
        queue_row(plan_row(ACT_REM_FREE, '0, '0, 4'd0, 1'b1, ST_NONE_FREE,
                           '0, '0, 1'b0, 5'd3));
        queue_row(plan_row(ACT_REM_ADDR, '1, '0, 4'd0, 1'b0, ST_OK,
                           '0, '0, 1'b0, 5'd0));
        queue_row(plan_row(ACT_READ, '0, '0, 4'd0, 1'b0, ST_OK, '0, '0, 1'b0, 5'd0));
        queue_row(plan_row(ACT_FREE_ALL, '0, '0, 4'd0, 1'b0, ST_OK,
                           '0, '0, 1'b0, 5'd0));
        queue_row(plan_row(ACT_REM_FREE, '0, '0, 4'd0, 1'b0, ST_OK,
                           '0, '0, 1'b0, 5'd0));
        queue_row(plan_row(ACT_READ, '0, '0, 4'd15, 1'b1, ST_BAD_INDEX,
                           '0, '0, 1'b0, 5'd1));
        queue_row(plan_row(ACT_READ, 32'hA5A5A5A5, 24'h5A5A5A, 4'd0, 1'b0, ST_OK,
                           '0, '0, 1'b0, 5'd0));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        fork
            begin
                foreach (directed_rows[d]) send_item(directed_rows[d]);
                // Random phases cycle through filling, mixed use and draining the table.
                for (n = 0; n < RANDOM_ITEMS; n++) begin
                    calm = (n >= 300 && n < 420);
                    if (n % 100 == 0) begin
                        for (k = 2; k < 8; k++) addr_pool[k] = $urandom;
                    end
                    mode = (n / 40) % 3;
                    roll = $urandom_range(99);
                    acc = 0;
                    pick = int'(ACT_UNUSED);
                    for (a = 0; a < 8; a++) begin
                        acc += mix[mode][a];
                        if (roll < acc) begin
                            pick = a;
                            break;
                        end
                    end
                    r = '0;
                    r.item.action = ACT_BITS'(pick);
                    r.item.buf_addr = ($urandom_range(99) < 75) ? addr_pool[$urandom_range(7)]
                                                                 : ADDR_BITS'($urandom);
                    r.item.buf_size = ($urandom_range(99) < 10) ? '1 : SIZE_BITS'($urandom);
                    r.item.index = INDEX_BITS'($urandom_range(15));
                    send_item(r);
                end
                calm = 1'b0;
                in_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge clk);
                repeat (DRAIN_CYCLES) @(posedge clk);
            end
            begin
                wait (stuck_cycles >= STUCK_LIMIT);
                $error("No handshake on either channel for %0d cycles", STUCK_LIMIT);
                error_count++;
            end
        join_any
        disable fork;

        $display("Run covered %0d items and %0d results, table count peaking at %0d.",
                 items_in, results_out, peak_count);
        $display("Outcomes: ok %0d, none free %0d, not found %0d, full %0d, bad index %0d.",
                 status_seen[ST_OK], status_seen[ST_NONE_FREE], status_seen[ST_NOT_FOUND],
                 status_seen[ST_FULL], status_seen[ST_BAD_INDEX]);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
